>>> design/wsdf_pkg.sv
// ----------------------------------------------------------------------------
// wsdf_pkg: shared types and constants of the WebSocket frame deframer
// Result kinds, opcodes, length markers and the queue entry format.
// ----------------------------------------------------------------------------
package wsdf_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;

	localparam int unsigned MAX_PAYLOAD_W = 21;
	localparam logic [MAX_PAYLOAD_W-1:0] MAX_PAYLOAD_RESET = 21'd8192;

	// result kinds
	localparam logic [2:0] KIND_TEXT     = 3'd0;
	localparam logic [2:0] KIND_BINARY   = 3'd1;
	localparam logic [2:0] KIND_CLOSE    = 3'd2;
	localparam logic [2:0] KIND_PING     = 3'd3;
	localparam logic [2:0] KIND_PONG     = 3'd4;
	localparam logic [2:0] KIND_UNKNOWN  = 3'd5;
	localparam logic [2:0] KIND_OVERSIZE = 3'd6;

	// frame opcodes
	localparam logic [3:0] OP_TEXT   = 4'h1;
	localparam logic [3:0] OP_BINARY = 4'h2;
	localparam logic [3:0] OP_CLOSE  = 4'h8;
	localparam logic [3:0] OP_PING   = 4'h9;
	localparam logic [3:0] OP_PONG   = 4'hA;

	// 7-bit length codes that announce an extended length
	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;

	// one queued result, still masked
	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] raw;
		logic [7:0] mask;
		logic       has_data;
		logic       last;
		logic       fin;
		logic [3:0] opcode;
	} entry_t;

	typedef struct packed {
		logic   push;
		entry_t entry;
	} push_t;

	function automatic logic [2:0] kind_of(input logic [3:0] op);
		logic [2:0] k;
		unique case (op)
			OP_TEXT:   k = KIND_TEXT;
			OP_BINARY: k = KIND_BINARY;
			OP_CLOSE:  k = KIND_CLOSE;
			OP_PING:   k = KIND_PING;
			OP_PONG:   k = KIND_PONG;
			default:   k = KIND_UNKNOWN;
		endcase
		return k;
	endfunction

	function automatic logic carries_data(input logic [2:0] kind);
		return (kind == KIND_TEXT) || (kind == KIND_BINARY) || (kind == KIND_PING);
	endfunction

endpackage

>>> design/wsdf_front.sv
// ----------------------------------------------------------------------------
// wsdf_front: frame header parser
// Walks the header bytes, tracks payload count and mask position, and
// queues one entry per result.
// ----------------------------------------------------------------------------
module wsdf_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                accept,
	input  logic [7:0]                          rx_byte,
	input  logic                                cfg_we,
	input  logic [wsdf_pkg::MAX_PAYLOAD_W-1:0]  cfg_wdata,
	output wsdf_pkg::push_t                     push
);

	typedef enum logic [5:0] {
		PH_HDR0    = 6'b000001,
		PH_HDR1    = 6'b000010,
		PH_EXTLEN  = 6'b000100,
		PH_MASK    = 6'b001000,
		PH_PAYLOAD = 6'b010000,
		PH_CLOSED  = 6'b100000
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [3:0]  cnt_q, cnt_d;
	logic [3:0]  opcode_q, opcode_d;
	logic        fin_q, fin_d;
	logic        masked_q, masked_d;
	logic [31:0] len_q, len_d;
	logic [31:0] remain_q, remain_d;
	logic [31:0] key_q, key_d;
	logic [1:0]  midx_q, midx_d;
	logic [wsdf_pkg::MAX_PAYLOAD_W-1:0] max_payload_q;

	logic [2:0]  kind;
	logic [31:0] ext_len;
	logic [7:0]  key_byte;
	logic        done_go;
	logic [31:0] done_len;
	logic        pay_last;

	assign kind    = wsdf_pkg::kind_of(opcode_q);
	assign ext_len = {len_q[23:0], rx_byte};

	always_comb begin
		unique case (midx_q)
			2'd0: key_byte = key_q[31:24];
			2'd1: key_byte = key_q[23:16];
			2'd2: key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	always_comb begin
		phase_d  = phase_q;
		cnt_d    = cnt_q;
		opcode_d = opcode_q;
		fin_d    = fin_q;
		masked_d = masked_q;
		len_d    = len_q;
		remain_d = remain_q;
		key_d    = key_q;
		midx_d   = midx_q;
		done_go  = 1'b0;
		done_len = len_q;
		pay_last = (remain_q == 32'd0) || (remain_q == 32'd1);
		push.push            = 1'b0;
		push.entry.kind      = kind;
		push.entry.raw       = 8'd0;
		push.entry.mask      = 8'd0;
		push.entry.has_data  = 1'b0;
		push.entry.last      = 1'b1;
		push.entry.fin       = fin_q;
		push.entry.opcode    = opcode_q;

		if (accept) begin
			unique case (phase_q)
				PH_HDR0: begin
					opcode_d = rx_byte[3:0];
					fin_d    = rx_byte[7];
					phase_d  = PH_HDR1;
				end
				PH_HDR1: begin
					masked_d = rx_byte[7];
					key_d    = 32'd0;
					len_d    = 32'd0;
					if (rx_byte[6:0] == wsdf_pkg::LEN_EXT16) begin
						cnt_d   = 4'd6;	// two bytes to go
						phase_d = PH_EXTLEN;
					end else if (rx_byte[6:0] == wsdf_pkg::LEN_EXT64) begin
						cnt_d   = 4'd0;
						phase_d = PH_EXTLEN;
					end else begin
						len_d = {25'd0, rx_byte[6:0]};
						cnt_d = 4'd0;
						if (rx_byte[7]) begin
							phase_d = PH_MASK;
						end else begin
							done_go  = 1'b1;
							done_len = {25'd0, rx_byte[6:0]};
						end
					end
				end
				PH_EXTLEN: begin
					len_d = ext_len;
					cnt_d = cnt_q + 4'd1;
					if (cnt_q == 4'd7) begin
						cnt_d = 4'd0;
						if (ext_len > {11'd0, max_payload_q}) begin
							phase_d             = PH_HDR0;
							push.push           = 1'b1;
							push.entry.kind     = wsdf_pkg::KIND_OVERSIZE;
						end else if (masked_q) begin
							phase_d = PH_MASK;
						end else begin
							done_go  = 1'b1;
							done_len = ext_len;
						end
					end
				end
				PH_MASK: begin
					key_d = {key_q[23:0], rx_byte};
					cnt_d = cnt_q + 4'd1;
					if (cnt_q == 4'd3) begin
						cnt_d    = 4'd0;
						done_go  = 1'b1;
						done_len = len_q;
					end
				end
				PH_PAYLOAD: begin
					midx_d   = midx_q + 2'd1;
					remain_d = (remain_q == 32'd0) ? 32'd0 : remain_q - 32'd1;
					if (pay_last)
						phase_d = (kind == wsdf_pkg::KIND_CLOSE) ? PH_CLOSED : PH_HDR0;
					if (wsdf_pkg::carries_data(kind)) begin
						push.push           = 1'b1;
						push.entry.raw      = rx_byte;
						push.entry.mask     = key_byte;
						push.entry.has_data = 1'b1;
						push.entry.last     = pay_last;
					end else if (pay_last) begin
						push.push = 1'b1;
					end
				end
				PH_CLOSED: begin
					// swallow everything until reset
				end
				default: begin
					phase_d = phase_q;
				end
			endcase

			// header complete: empty frames finish here
			if (done_go) begin
				midx_d = 2'd0;
				if (done_len == 32'd0) begin
					phase_d   = (kind == wsdf_pkg::KIND_CLOSE) ? PH_CLOSED : PH_HDR0;
					push.push = 1'b1;
				end else begin
					remain_d = done_len;
					phase_d  = PH_PAYLOAD;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_HDR0;
			cnt_q         <= 4'd0;
			opcode_q      <= 4'd0;
			fin_q         <= 1'b0;
			masked_q      <= 1'b0;
			len_q         <= 32'd0;
			remain_q      <= 32'd0;
			key_q         <= 32'd0;
			midx_q        <= 2'd0;
			max_payload_q <= wsdf_pkg::MAX_PAYLOAD_RESET;
		end else begin
			phase_q  <= phase_d;
			cnt_q    <= cnt_d;
			opcode_q <= opcode_d;
			fin_q    <= fin_d;
			masked_q <= masked_d;
			len_q    <= len_d;
			remain_q <= remain_d;
			key_q    <= key_d;
			midx_q   <= midx_d;
			if (cfg_we)
				max_payload_q <= cfg_wdata;
		end
	end

`ifndef NO_ASSERTIONS
	a_closed_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_CLOSED) |=> (phase_q == PH_CLOSED))
		else $error("deframer left closed state without reset");
	a_closed_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_CLOSED) |-> !push.push)
		else $error("result queued while closed");
`endif

endmodule

>>> design/wsdf_queue.sv
// ----------------------------------------------------------------------------
// wsdf_queue: result queue between parser and output stage
// Small circular buffer; parser pushes, output stage pops.
// ----------------------------------------------------------------------------
module wsdf_queue #(
	parameter int unsigned DEPTH = wsdf_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  wsdf_pkg::push_t   push,
	input  logic              pop,
	output wsdf_pkg::entry_t  head,
	output logic              empty,
	output logic              full
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	wsdf_pkg::entry_t mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign empty = (count_q == CW'(0));
	assign full  = (count_q == CW'(DEPTH));
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.push)
			mem_q[wr_ptr_q] <= push.entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.push)
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			priority if (push.push && !pop)
				count_q <= count_q + CW'(1);
			else if (pop && !push.push)
				count_q <= count_q - CW'(1);
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(full && !pop) |-> !push.push)
		else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop)
		else $error("queue underflow");
`endif

endmodule

>>> design/wsdf_back.sv
// ----------------------------------------------------------------------------
// wsdf_back: unmask and output register
// Pops queued results, applies the mask byte and holds the result transaction.
// ----------------------------------------------------------------------------
module wsdf_back (
	input  logic              clk,
	input  logic              arst_n,
	input  wsdf_pkg::entry_t  head,
	input  logic              empty,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [2:0]        frame_kind,
	output logic [7:0]        payload_byte,
	output logic              has_data,
	output logic              last,
	output logic              fin_flag,
	output logic [3:0]        raw_opcode
);

	logic       valid_q;
	logic [2:0] kind_q;
	logic [7:0] byte_q;
	logic       has_q;
	logic       last_q;
	logic       fin_q;
	logic [3:0] opcode_q;

	assign pop = !empty && (!valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || out_ready) begin
			valid_q <= !empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q   <= head.kind;
			byte_q   <= head.has_data ? (head.raw ^ head.mask) : 8'd0;
			has_q    <= head.has_data;
			last_q   <= head.last;
			fin_q    <= head.fin;
			opcode_q <= head.opcode;
		end
	end

	assign out_valid    = valid_q;
	assign frame_kind   = kind_q;
	assign payload_byte = byte_q;
	assign has_data     = has_q;
	assign last         = last_q;
	assign fin_flag     = fin_q;
	assign raw_opcode   = opcode_q;

`ifndef NO_ASSERTIONS
	a_nodata_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !has_q) |-> (last_q && (byte_q == 8'd0)))
		else $error("result without data is not a clean end marker");
`endif

endmodule

>>> design/websocket_frame_deframer.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer: WebSocket receive-side frame parser
// Parses frame headers byte by byte, unmasks payload and reports frame ends.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready/rx_byte carries the raw stream, one byte
//   per transaction. Output channel out_valid/out_ready carries one result per
//   transaction: a payload byte of a text, binary or ping frame, or a single
//   end-of-frame marker for close, pong, unknown opcodes, empty frames and
//   oversize 16/64-bit lengths (compared against max_payload).
//   cfg_we/cfg_wdata write max_payload; write it only while the block is idle.
//   Throughput: one byte per clock, sustained, as long as the output side
//   drains; in_ready drops only when the result queue is full.
//   A result is written into the queue at the edge that accepts its byte
//   and moves into the output register once that register is free.
//   A stalled receiver fills the queue (QUEUE_DEPTH entries plus the output
//   register) before in_ready is pulled low; nothing is lost.
//   Reset: parser returns to awaiting a header, queue empties, max_payload
//   returns to 8192. After a close frame all input is consumed and dropped
//   until the next reset.
// ----------------------------------------------------------------------------
module websocket_frame_deframer #(
	parameter int unsigned QUEUE_DEPTH = wsdf_pkg::QUEUE_DEPTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// byte stream
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [7:0]                          rx_byte,
	// configuration
	input  logic                                cfg_we,
	input  logic [wsdf_pkg::MAX_PAYLOAD_W-1:0]  cfg_wdata,
	// results
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [2:0]                          frame_kind,
	output logic [7:0]                          payload_byte,
	output logic                                has_data,
	output logic                                last,
	output logic                                fin_flag,
	output logic [3:0]                          raw_opcode
);

	wsdf_pkg::push_t  push;
	wsdf_pkg::entry_t head;
	logic             q_empty;
	logic             q_full;
	logic             pop;
	logic             accept;

	// Only the full queue holds the parser back.
	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	wsdf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.rx_byte   (rx_byte),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.push      (push)
	);

	wsdf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.empty  (q_empty),
		.full   (q_full)
	);

	wsdf_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.empty        (q_empty),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.frame_kind   (frame_kind),
		.payload_byte (payload_byte),
		.has_data     (has_data),
		.last         (last),
		.fin_flag     (fin_flag),
		.raw_opcode   (raw_opcode)
	);

endmodule
